// ===== rtl/core/stlrc_pkg.sv =====
// Package for the scanline timing run counter.
// Holds the request and result structs, the line summary and shared codes.
// No dependencies.
package stlrc_pkg;

    // Fixed field widths
    localparam int RUN_W   = 11;
    localparam int COUNT_W = 10;
    localparam int MRUN_W  = 4;
    localparam int PCT_W   = 7;
    localparam int MOD_W   = 11;
    localparam int CFG_W   = 7;

    // Saturation limits and reset values of the line state
    localparam logic [COUNT_W-1:0] COUNT_CAP   = 10'd1023;
    localparam logic [RUN_W-1:0]   SHORT_RESET = 11'd2047;
    localparam logic [RUN_W-1:0]   RUN_HW_CAP  = 11'd2047;

    // Percent scale of the ratio test
    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

    // Register reset values
    localparam logic [MRUN_W-1:0] MIN_RUN_RESET   = 4'd1;
    localparam logic [PCT_W-1:0]  MIN_RATIO_RESET = 7'd30;

    // Queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    // Register indexes
    typedef enum logic
    {
        CFG_MIN_RUN   = 1'b0,
        CFG_MIN_RATIO = 1'b1
    } cfg_index_t;

    // Result codes
    typedef enum logic [1:0]
    {
        CAUSE_OK           = 2'd0,
        CAUSE_BRIGHT_RATIO = 2'd1,
        CAUSE_DARK_RATIO   = 2'd2,
        CAUSE_COUNT        = 2'd3
    } fail_cause_t;

    // Input request
    typedef struct packed
    {
        logic pixel_bright;
        logic last_pixel;
    } in_item_t;

    // Result item
    typedef struct packed
    {
        logic             line_valid;
        logic [MOD_W-1:0] module_count;
        logic [1:0]       fail_cause;
    } out_item_t;

    // Per-line tallies handed from front to back
    typedef struct packed
    {
        logic [COUNT_W-1:0] bright_runs;
        logic [RUN_W-1:0]   bright_shortest;
        logic [RUN_W-1:0]   bright_longest;
        logic [COUNT_W-1:0] dark_runs;
        logic [RUN_W-1:0]   dark_shortest;
        logic [RUN_W-1:0]   dark_longest;
    } line_summary_t;

endpackage

// ===== rtl/core/stlrc_front.sv =====
// Front part: tracks bright and dark runs one accepted pixel per clock and tallies them.
// Pushes one line summary on the last pixel. Depends on stlrc_pkg.
module stlrc_front
    import stlrc_pkg::*;
#(
    parameter int MAX_LINE = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  in_item_t            item,
    input  logic [MRUN_W-1:0]   min_run,
    output logic                push,
    output line_summary_t       summary
);

    localparam logic [RUN_W-1:0] RUN_CAP =
        (MAX_LINE < 2047) ? RUN_W'(MAX_LINE) : RUN_HW_CAP;

    logic               in_bright_reg, in_bright_next;
    logic               seen_bright_reg, seen_bright_next;
    logic [RUN_W-1:0]   run_length_reg, run_length_next;
    logic [COUNT_W-1:0] bright_runs_reg, bright_runs_next;
    logic [RUN_W-1:0]   bright_shortest_reg, bright_shortest_next;
    logic [RUN_W-1:0]   bright_longest_reg, bright_longest_next;
    logic [COUNT_W-1:0] dark_runs_reg, dark_runs_next;
    logic [RUN_W-1:0]   dark_shortest_reg, dark_shortest_next;
    logic [RUN_W-1:0]   dark_longest_reg, dark_longest_next;

    logic [RUN_W-1:0]   grown;
    logic [RUN_W-1:0]   close_len;
    logic               close_en;
    logic               counted;
    logic               tally_bright;
    logic               tally_dark;
    line_summary_t      tallied;

    // Saturating run growth
    assign grown = (run_length_reg < RUN_CAP) ? (run_length_reg + 1'b1) : run_length_reg;

    // Close the current run on a color change, or on the last pixel after growing it
    assign close_en     = item.last_pixel || (item.pixel_bright != in_bright_reg);
    assign close_len    = item.last_pixel ? grown : run_length_reg;
    assign counted      = close_en && (close_len > {{(RUN_W-MRUN_W){1'b0}}, min_run});
    assign tally_bright = counted && in_bright_reg;
    assign tally_dark   = counted && !in_bright_reg && seen_bright_reg;

    // Tally the closed run into its color
    always_comb
    begin
        tallied.bright_runs     = bright_runs_reg;
        tallied.bright_shortest = bright_shortest_reg;
        tallied.bright_longest  = bright_longest_reg;
        tallied.dark_runs       = dark_runs_reg;
        tallied.dark_shortest   = dark_shortest_reg;
        tallied.dark_longest    = dark_longest_reg;
        if (tally_bright)
        begin
            if (bright_runs_reg < COUNT_CAP)
                tallied.bright_runs = bright_runs_reg + 1'b1;
            if (close_len < bright_shortest_reg)
                tallied.bright_shortest = close_len;
            if (close_len > bright_longest_reg)
                tallied.bright_longest = close_len;
        end
        if (tally_dark)
        begin
            if (dark_runs_reg < COUNT_CAP)
                tallied.dark_runs = dark_runs_reg + 1'b1;
            if (close_len < dark_shortest_reg)
                tallied.dark_shortest = close_len;
            if (close_len > dark_longest_reg)
                tallied.dark_longest = close_len;
        end
    end

    assign push    = accept && item.last_pixel;
    assign summary = tallied;

    // Advance the line state; clear it after the last pixel
    always_comb
    begin
        in_bright_next       = in_bright_reg;
        seen_bright_next     = seen_bright_reg;
        run_length_next      = run_length_reg;
        bright_runs_next     = bright_runs_reg;
        bright_shortest_next = bright_shortest_reg;
        bright_longest_next  = bright_longest_reg;
        dark_runs_next       = dark_runs_reg;
        dark_shortest_next   = dark_shortest_reg;
        dark_longest_next    = dark_longest_reg;
        if (accept)
        begin
            if (item.last_pixel)
            begin
                in_bright_next       = 1'b0;
                seen_bright_next     = 1'b0;
                run_length_next      = '0;
                bright_runs_next     = '0;
                bright_shortest_next = SHORT_RESET;
                bright_longest_next  = '0;
                dark_runs_next       = '0;
                dark_shortest_next   = SHORT_RESET;
                dark_longest_next    = '0;
            end
            else if (item.pixel_bright == in_bright_reg)
            begin
                run_length_next = grown;
            end
            else
            begin
                in_bright_next       = item.pixel_bright;
                seen_bright_next     = seen_bright_reg | item.pixel_bright;
                run_length_next      = RUN_W'(1);
                bright_runs_next     = tallied.bright_runs;
                bright_shortest_next = tallied.bright_shortest;
                bright_longest_next  = tallied.bright_longest;
                dark_runs_next       = tallied.dark_runs;
                dark_shortest_next   = tallied.dark_shortest;
                dark_longest_next    = tallied.dark_longest;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_bright_reg       <= 1'b0;
            seen_bright_reg     <= 1'b0;
            run_length_reg      <= '0;
            bright_runs_reg     <= '0;
            bright_shortest_reg <= SHORT_RESET;
            bright_longest_reg  <= '0;
            dark_runs_reg       <= '0;
            dark_shortest_reg   <= SHORT_RESET;
            dark_longest_reg    <= '0;
        end
        else
        begin
            in_bright_reg       <= in_bright_next;
            seen_bright_reg     <= seen_bright_next;
            run_length_reg      <= run_length_next;
            bright_runs_reg     <= bright_runs_next;
            bright_shortest_reg <= bright_shortest_next;
            bright_longest_reg  <= bright_longest_next;
            dark_runs_reg       <= dark_runs_next;
            dark_shortest_reg   <= dark_shortest_next;
            dark_longest_reg    <= dark_longest_next;
        end
    end

endmodule

// ===== rtl/core/stlrc_queue.sv =====
// Short queue of line summaries between the front and the back part.
// Depends on stlrc_pkg.
module stlrc_queue
    import stlrc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  line_summary_t push_data,
    input  logic          pop,
    output line_summary_t pop_data,
    output logic          full,
    output logic          empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    line_summary_t    entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== rtl/core/stlrc_back.sv =====
// Back part: judges one line summary and holds the result in an output register.
// Ratio tests use exact cross-multiplication. Depends on stlrc_pkg.
module stlrc_back
    import stlrc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             queue_empty,
    input  line_summary_t    summary,
    input  logic [PCT_W-1:0] min_ratio_percent,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data
);

    localparam int PROD_W = RUN_W + PCT_W;

    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg;
    out_item_t         judged;
    logic [PROD_W-1:0] bright_lo_scaled, bright_hi_scaled;
    logic [PROD_W-1:0] dark_lo_scaled, dark_hi_scaled;
    logic              bright_fail;
    logic              dark_fail;
    logic              count_ok;

    // Cross-multiply shortest by 100 and longest by the percent
    assign bright_lo_scaled = PROD_W'(summary.bright_shortest) * PROD_W'(PCT_SCALE);
    assign bright_hi_scaled = PROD_W'(summary.bright_longest) * PROD_W'(min_ratio_percent);
    assign dark_lo_scaled   = PROD_W'(summary.dark_shortest) * PROD_W'(PCT_SCALE);
    assign dark_hi_scaled   = PROD_W'(summary.dark_longest) * PROD_W'(min_ratio_percent);

    assign bright_fail = (summary.bright_runs != '0) && (bright_lo_scaled < bright_hi_scaled);
    assign dark_fail   = (summary.dark_runs != '0) && (dark_lo_scaled < dark_hi_scaled);
    assign count_ok    = (summary.bright_runs == summary.dark_runs)
                      || ({1'b0, summary.bright_runs} == ({1'b0, summary.dark_runs} + 1'b1));

    // Pick the first failing check
    always_comb
    begin
        judged.line_valid   = 1'b0;
        judged.module_count = '0;
        if (bright_fail)
            judged.fail_cause = CAUSE_BRIGHT_RATIO;
        else if (dark_fail)
            judged.fail_cause = CAUSE_DARK_RATIO;
        else if (!count_ok)
            judged.fail_cause = CAUSE_COUNT;
        else
        begin
            judged.fail_cause   = CAUSE_OK;
            judged.line_valid   = 1'b1;
            judged.module_count = {summary.dark_runs, 1'b0};
        end
    end

    // Take a summary whenever the output register is free or draining
    assign pop = !queue_empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        if (pop)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_data_reg <= judged;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/core/scanline_timing_run_counter.sv =====
// Scanline timing run counter: takes one pixel per clock unless the queue is full.
// When its last pixel is accepted, a line's summary enters the queue; the judging
// stage registers its result once the output register is free or draining.
// Pixel requests stall only while the two-entry summary queue is full.
// Reset clears the line state, empties the queue and drops any held result;
// min_run returns to 1 and min_ratio_percent to 30.
module scanline_timing_run_counter
    import stlrc_pkg::*;
#(
    parameter int MAX_LINE = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data,
    input  logic             cfg_wr_en,
    input  cfg_index_t       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [MRUN_W-1:0] min_run_reg;
    logic [PCT_W-1:0]  min_ratio_reg;
    logic              in_accept;
    logic              front_push;
    line_summary_t     front_summary;
    line_summary_t     back_summary;
    logic              back_pop;
    logic              q_full;
    logic              q_empty;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_run_reg   <= MIN_RUN_RESET;
            min_ratio_reg <= MIN_RATIO_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MIN_RUN:   min_run_reg   <= cfg_data[MRUN_W-1:0];
                CFG_MIN_RATIO: min_ratio_reg <= cfg_data[PCT_W-1:0];
                default:       min_run_reg   <= min_run_reg;
            endcase
        end
    end

    assign in_stall  = q_full;
    assign in_accept = in_valid && !q_full;

    stlrc_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_accept),
        .item    (in_data),
        .min_run (min_run_reg),
        .push    (front_push),
        .summary (front_summary)
    );

    stlrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (front_summary),
        .pop       (back_pop),
        .pop_data  (back_summary),
        .full      (q_full),
        .empty     (q_empty)
    );

    stlrc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .queue_empty       (q_empty),
        .summary           (back_summary),
        .min_ratio_percent (min_ratio_reg),
        .pop               (back_pop),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .out_data          (out_data)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for scanline_timing_run_counter.
// Depends on stlrc_pkg and the block; a built-in line tally predicts each result.

module tb_top;

    import stlrc_pkg::*;

    // Run limits and pacing
    localparam int LINE_CAP     = 1024;     // run length cap at the default MAX_LINE
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int TIMEOUT_NS   = 4000000;

    // Table shorthand
    localparam logic DARK    = 1'b0;
    localparam logic BRIGHT  = 1'b1;
    localparam logic MORE    = 1'b0;
    localparam logic LAST    = 1'b1;
    localparam logic TYPED   = 1'b1;
    localparam logic PREDICT = 1'b0;

    // One pixel request, with an optional hand-typed result for the line it ends
    typedef struct packed
    {
        in_item_t  px;
        logic      fixed;
        out_item_t want;
    } pixel_req_t;

    // Directed lines at the reset settings (min_run 1, 30 percent)
    localparam pixel_req_t DIRECTED [20] = '{
        // one dark pixel
        {DARK,   LAST, TYPED,   1'b1, 11'd0, CAUSE_OK},
        // one bright pixel
        {BRIGHT, LAST, TYPED,   1'b1, 11'd0, CAUSE_OK},
        // no bright pixel at all
        {DARK,   MORE, PREDICT, 14'd0},
        {DARK,   MORE, PREDICT, 14'd0},
        {DARK,   LAST, TYPED,   1'b1, 11'd0, CAUSE_OK},
        // leading dark run, then two bright and two dark modules
        {DARK,   MORE, PREDICT, 14'd0},
        {DARK,   MORE, PREDICT, 14'd0},
        {BRIGHT, MORE, PREDICT, 14'd0},
        {BRIGHT, MORE, PREDICT, 14'd0},
        {DARK,   MORE, PREDICT, 14'd0},
        {DARK,   MORE, PREDICT, 14'd0},
        {BRIGHT, MORE, PREDICT, 14'd0},
        {BRIGHT, MORE, PREDICT, 14'd0},
        {DARK,   MORE, PREDICT, 14'd0},
        {DARK,   LAST, TYPED,   1'b1, 11'd4, CAUSE_OK},
        // short dark run drops out, leaving two bright runs against none
        {BRIGHT, MORE, PREDICT, 14'd0},
        {BRIGHT, MORE, PREDICT, 14'd0},
        {DARK,   MORE, PREDICT, 14'd0},
        {BRIGHT, MORE, PREDICT, 14'd0},
        {BRIGHT, LAST, TYPED,   1'b0, 11'd0, CAUSE_COUNT}
    };

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_stall;
    out_item_t        out_data;
    logic             cfg_wr_en;
    cfg_index_t       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    // Predictor copy of the registers and the line tallies (index 1 bright, 0 dark)
    logic [MRUN_W-1:0]  cur_min_run;
    logic [PCT_W-1:0]   cur_pct;
    logic               px_in_bright;
    logic               px_seen_bright;
    logic [RUN_W-1:0]   run_len;
    logic [COUNT_W-1:0] runs_of [2];
    logic [RUN_W-1:0]   shortest_of [2];
    logic [RUN_W-1:0]   longest_of [2];

    pixel_req_t pixel_plan [$];
    out_item_t  lines_due [$];
    pixel_req_t cur_req;
    logic       req_taken;
    int         px_queued;
    int         px_accepted;
    int         errors;
    int         idle_pct;
    int         gap_left;
    int         stall_left;
    int         hold_left;
    logic       hold_req;

    scanline_timing_run_counter u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    task automatic clear_line();
        px_in_bright   = 1'b0;
        px_seen_bright = 1'b0;
        run_len        = '0;
        for (int c = 0; c < 2; c++)
        begin
            runs_of[c]     = '0;
            shortest_of[c] = SHORT_RESET;
            longest_of[c]  = '0;
        end
    endtask

    task automatic grow_run();
        if (run_len < LINE_CAP)
            run_len++;
    endtask

    // Fold the finished run into its color; a leading dark run never counts
    task automatic close_run();
        int c;
        c = px_in_bright ? 1 : 0;
        if (!px_seen_bright || run_len <= cur_min_run)
            return;
        if (runs_of[c] < COUNT_CAP)
            runs_of[c]++;
        if (run_len < shortest_of[c])
            shortest_of[c] = run_len;
        if (run_len > longest_of[c])
            longest_of[c] = run_len;
    endtask

    // Exact percent test by cross-multiplication; a color with no runs passes
    function automatic logic ratio_low(input int c);
        if (runs_of[c] == 0)
            return 1'b0;
        return int'(shortest_of[c]) * int'(PCT_SCALE) < int'(cur_pct) * int'(longest_of[c]);
    endfunction

    function automatic out_item_t judge_line();
        out_item_t r;
        r = '0;
        if (ratio_low(1))
            r.fail_cause = CAUSE_BRIGHT_RATIO;
        else if (ratio_low(0))
            r.fail_cause = CAUSE_DARK_RATIO;
        else if (int'(runs_of[1]) == int'(runs_of[0]) ||
                 int'(runs_of[1]) == int'(runs_of[0]) + 1)
        begin
            r.line_valid   = 1'b1;
            r.module_count = {runs_of[0], 1'b0};
            r.fail_cause   = CAUSE_OK;
        end
        else
            r.fail_cause = CAUSE_COUNT;
        return r;
    endfunction

    // Advance the line by one pixel; the final pixel always extends the run
    task automatic follow_pixel(input in_item_t p, output logic produced,
                                output out_item_t res);
        produced = 1'b0;
        res      = '0;
        if (!p.last_pixel)
        begin
            if (p.pixel_bright == px_in_bright)
                grow_run();
            else
            begin
                close_run();
                px_in_bright = p.pixel_bright;
                if (p.pixel_bright)
                    px_seen_bright = 1'b1;
                run_len = RUN_W'(1);
            end
        end
        else
        begin
            grow_run();
            close_run();
            res      = judge_line();
            produced = 1'b1;
            clear_line();
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    task automatic plan_pixel(input logic bright, input logic last);
        pixel_req_t r;
        r                 = '0;
        r.px.pixel_bright = bright;
        r.px.last_pixel   = last;
        pixel_plan.insert(pixel_plan.size(), r);
        px_queued++;
    endtask

    // Timing pattern: optional dark lead, alternating runs near one module size
    task automatic plan_pattern_line();
        int   m;
        int   len;
        logic color;
        m     = $urandom_range(1, cur_min_run + 4);
        color = BRIGHT;
        repeat ($urandom_range(0, 3)) plan_pixel(DARK, MORE);
        repeat ($urandom_range(1, 14))
        begin
            len = m;
            case ($urandom_range(0, 9))
                0:       len = 1;
                1:       len = m * 3;
                2, 3:    len = m + 1;
                4:       len = (m > 1) ? m - 1 : m;
                default: len = m;
            endcase
            repeat (len) plan_pixel(color, MORE);
            color = ~color;
        end
        plan_pixel(1'($urandom_range(0, 1)), LAST);
    endtask

    task automatic plan_noise_line();
        repeat ($urandom_range(0, 40)) plan_pixel(1'($urandom_range(0, 1)), MORE);
        plan_pixel(1'($urandom_range(0, 1)), LAST);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_MIN_RUN)
            cur_min_run = value[MRUN_W-1:0];
        else
            cur_pct = value[PCT_W-1:0];
    endtask

    // Hold until every request is taken and every line result is back
    task automatic wait_idle();
        while (px_accepted != px_queued || lines_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input int mr, input int pct, input int idle, input int budget);
        int goal;
        write_reg(CFG_MIN_RUN, CFG_W'(mr));
        write_reg(CFG_MIN_RATIO, CFG_W'(pct));
        idle_pct = idle;
        goal     = px_queued + budget;
        while (px_queued < goal)
        begin
            if ($urandom_range(0, 4) == 0)
                plan_noise_line();
            else
                plan_pattern_line();
        end
        wait_idle();
    endtask

    task automatic check_field(input string what, input logic [MOD_W-1:0] want,
                               input logic [MOD_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // ---------------------------------------------------------------- drivers

    // Offer pixel requests; hold a stalled request, drop valid in idle bursts
    always @(negedge clk)
    begin : drive_pixels
        if (rst_n)
        begin
            if (in_valid && !req_taken)
                ;
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pixel_plan.size() == 0)
                in_valid <= 1'b0;
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                gap_left = $urandom_range(0, 12);
                in_valid <= 1'b0;
            end
            else
            begin
                cur_req = pixel_plan.pop_front();
                in_data  <= cur_req.px;
                in_valid <= 1'b1;
            end
            req_taken = 1'b0;
        end
    end

    // Stall results in random bursts, or for one long hold when asked
    always @(negedge clk)
    begin : drive_stall
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                stall_left = $urandom_range(0, 12);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Predict on every accepted pixel request
    always @(posedge clk)
    begin : take_pixel
        logic      produced;
        out_item_t res;
        if (rst_n && in_valid && !in_stall)
        begin
            follow_pixel(in_data, produced, res);
            if (produced)
                lines_due.insert(lines_due.size(), cur_req.fixed ? cur_req.want : res);
            px_accepted++;
            req_taken = 1'b1;
        end
    end

    // Compare every accepted result with the oldest one due
    always @(posedge clk)
    begin : check_result
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (lines_due.size() == 0)
            begin
                $display("%0t: no result expected, got valid %0d count %0d cause %0d",
                         $time, out_data.line_valid, out_data.module_count,
                         out_data.fail_cause);
                errors++;
            end
            else
            begin
                want = lines_due.pop_front();
                check_field("line_valid", MOD_W'(want.line_valid),
                            MOD_W'(out_data.line_valid));
                check_field("module_count", want.module_count, out_data.module_count);
                check_field("fail_cause", MOD_W'(want.fail_cause),
                            MOD_W'(out_data.fail_cause));
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin : run_main
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_stall  = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_MIN_RUN;
        cfg_data   = '0;
        req_taken  = 1'b0;
        hold_req   = 1'b0;
        px_queued  = 0;
        px_accepted = 0;
        errors     = 0;
        idle_pct   = 0;
        gap_left   = 0;
        stall_left = 0;
        hold_left  = 0;
        cur_min_run = MIN_RUN_RESET;
        cur_pct     = MIN_RATIO_RESET;
        clear_line();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed lines at the reset settings
        idle_pct = 20;
        foreach (DIRECTED[i])
        begin
            pixel_plan.insert(pixel_plan.size(), DIRECTED[i]);
            px_queued++;
        end
        wait_idle();

        // Register extremes, including a percent above 100
        run_phase(0, 0, 25, 150);
        run_phase(15, 100, 0, 150);
        run_phase(1, 127, 40, 100);

        // Saturate the run length with one long bright run
        write_reg(CFG_MIN_RUN, 7'd0);
        write_reg(CFG_MIN_RATIO, 7'd50);
        idle_pct = 10;
        repeat (3) plan_pixel(DARK, MORE);
        repeat (1028) plan_pixel(BRIGHT, MORE);
        repeat (4) plan_pixel(DARK, MORE);
        repeat (6) plan_pixel(BRIGHT, MORE);
        plan_pixel(DARK, LAST);
        wait_idle();

        // Back up results with a long hold while one-pixel lines keep coming
        write_reg(CFG_MIN_RUN, 7'd2);
        write_reg(CFG_MIN_RATIO, 7'd30);
        idle_pct = 0;
        hold_req = 1'b1;
        repeat (40) plan_pixel(1'($urandom_range(0, 1)), LAST);
        wait_idle();

        repeat (3) run_phase($urandom_range(0, 15), $urandom_range(0, 127),
                             $urandom_range(10, 50), 70);

        // Finish at full rate on both sides
        run_phase(3, 45, 0, 80);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/stlrc_pkg.sv
rtl/core/stlrc_front.sv
rtl/core/stlrc_queue.sv
rtl/core/stlrc_back.sv
rtl/core/scanline_timing_run_counter.sv
tb/tb_top.sv
